/* rtl/ipv4_packet_blocklist_filter_unit_macros.svh */
// assertion macros shared by the blocklist filter checker
`ifndef IPV4_PACKET_BLOCKLIST_FILTER_UNIT_MACROS_SVH
`define IPV4_PACKET_BLOCKLIST_FILTER_UNIT_MACROS_SVH

// property checked only outside reset
`define IPBF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ipbf assertion failed");

// property checked at every edge, reset included
`define IPBF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ipbf assertion failed");

`endif

/* rtl/ipbf_pkg.sv */
// shared types and constants of the ipv4 blocklist filter
`timescale 1ns / 1ps

package ipbf_pkg;

  // default number of slots in each block table
  localparam int unsigned TableEntriesDef = 16;
  // width of the slot index on the write port
  localparam int unsigned EntryIdxW = 4;

  // frame constants
  localparam logic [15:0] EthPIp     = 16'h0800;
  localparam logic [7:0]  IpprotoTcp = 8'd6;
  localparam logic [7:0]  IpprotoUdp = 8'd17;
  localparam logic [6:0]  MinIpv4Len = 7'd34;
  localparam logic [6:0]  MinUdpLen  = 7'd42;
  localparam logic [6:0]  MinTcpLen  = 7'd54;
  localparam logic [5:0]  CountMax   = 6'd63;

  // verdict codes
  localparam logic VerdictPass = 1'b0;
  localparam logic VerdictDrop = 1'b1;

  typedef enum logic {
    ActPacket = 1'b0,
    ActWrite  = 1'b1
  } ipbf_action_e;

  typedef enum logic [1:0] {
    TblSrc   = 2'd0,
    TblDst   = 2'd1,
    TblProto = 2'd2,
    TblPort  = 2'd3
  } ipbf_table_e;

  // one input transaction as held in the input register
  typedef struct packed {
    ipbf_action_e   action;
    logic [7:0]     data_byte;
    logic           last_byte;
    ipbf_table_e    table_select;
    logic [EntryIdxW-1:0] entry_index;
    logic [31:0]    entry_key;
    logic           entry_present;
  } ipbf_item_t;

  // header fields captured from the frame
  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_port;
  } ipbf_frame_t;

endpackage

/* rtl/ipbf_parser.sv */
// byte counter and header field capture for one frame
`timescale 1ns / 1ps

module ipbf_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output ipbf_pkg::ipbf_frame_t frame_o,
  output logic [5:0]            count_o
);

  logic [5:0]            count_q, count_d;
  ipbf_pkg::ipbf_frame_t frame_q, frame_d;
  ipbf_pkg::ipbf_frame_t frame_cap;

  // fields with the current byte applied at its offset
  always_comb begin
    frame_cap = frame_q;
    case (count_q) inside
      6'd12, 6'd13: frame_cap.ether_type = {frame_q.ether_type[7:0], data_byte_i};
      6'd23: frame_cap.protocol = data_byte_i;
      [6'd26:6'd29]: frame_cap.src_addr = {frame_q.src_addr[23:0], data_byte_i};
      [6'd30:6'd33]: frame_cap.dst_addr = {frame_q.dst_addr[23:0], data_byte_i};
      6'd36, 6'd37: frame_cap.l4_port = {frame_q.l4_port[7:0], data_byte_i};
      default: frame_cap = frame_q;
    endcase
  end

  // frame state clears after the last byte, counter saturates
  always_comb begin
    frame_d = frame_q;
    count_d = count_q;
    if (en_i) begin
      if (last_byte_i) begin
        frame_d = '0;
        count_d = '0;
      end else begin
        frame_d = frame_cap;
        if (count_q < ipbf_pkg::CountMax) begin
          count_d = count_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      count_q <= '0;
    end else begin
      frame_q <= frame_d;
      count_q <= count_d;
    end
  end

  assign frame_o = frame_cap;
  assign count_o = count_q;

endmodule

/* rtl/ipbf_table.sv */
// one block table: keyed slots with present bits and a parallel match
`timescale 1ns / 1ps

module ipbf_table #(
  parameter int unsigned Entries = ipbf_pkg::TableEntriesDef,
  parameter int unsigned KeyW    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ipbf_pkg::EntryIdxW-1:0] wr_index_i,
  input  logic [KeyW-1:0]               wr_key_i,
  input  logic                          wr_present_i,
  input  logic [KeyW-1:0]               lookup_i,
  output logic                          hit_o
);

  localparam int unsigned IdxW = ipbf_pkg::EntryIdxW;

  logic [Entries-1:0] present_q;
  logic [KeyW-1:0]    key_q [Entries];

  // present bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else begin
      for (int i = 0; i < Entries; i++) begin
        if (wr_en_i && (wr_index_i == IdxW'(i))) begin
          present_q[i] <= wr_present_i;
        end
      end
    end
  end

  // key storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (wr_en_i && (wr_index_i == IdxW'(i))) begin
        key_q[i] <= wr_key_i;
      end
    end
  end

  // match against every present slot
  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (present_q[i] && (key_q[i] == lookup_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

/* rtl/ipv4_packet_blocklist_filter_unit.sv */
// top level of the ipv4 blocklist packet filter
// a last frame byte waits in the input register once accepted, and its verdict is loaded
//   into the result register when that byte advances, which it does only past a free output
// throughput: one transaction per cycle, set by the single-pass table match, while no result stalls
// reset: clears frame state and all present bits at once, no clearing pass
`timescale 1ns / 1ps

module ipv4_packet_blocklist_filter_unit #(
  parameter int unsigned TABLE_ENTRIES = ipbf_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  input  logic [1:0]                     table_select_i,
  input  logic [ipbf_pkg::EntryIdxW-1:0] entry_index_i,
  input  logic [31:0]                    entry_key_i,
  input  logic                           entry_present_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           verdict_o
);

  // slots beyond the index range can never be written
  localparam int unsigned IdxSpan    = 1 << ipbf_pkg::EntryIdxW;
  localparam int unsigned TableDepth = (TABLE_ENTRIES < IdxSpan) ? TABLE_ENTRIES : IdxSpan;

  ipbf_pkg::ipbf_item_t  item_q;
  logic                  item_valid_q, item_valid_d;
  logic                  out_valid_q, out_valid_d;
  logic                  verdict_q, verdict_d;
  logic                  produces, advance, in_accept;
  logic                  pkt_en, wr_en;
  ipbf_pkg::ipbf_frame_t frame;
  logic [5:0]            count;
  logic [6:0]            frame_len;
  logic                  src_hit, dst_hit, proto_hit, port_hit;
  logic                  is_tcp, is_udp;

  // input register handshake
  assign produces   = (item_q.action == ipbf_pkg::ActPacket) && item_q.last_byte;
  assign advance    = item_valid_q && (!produces || !out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.action        <= ipbf_pkg::ipbf_action_e'(action_i);
      item_q.data_byte     <= data_byte_i;
      item_q.last_byte     <= last_byte_i;
      item_q.table_select  <= ipbf_pkg::ipbf_table_e'(table_select_i);
      item_q.entry_index   <= entry_index_i;
      item_q.entry_key     <= entry_key_i;
      item_q.entry_present <= entry_present_i;
    end
  end

  assign pkt_en = advance && (item_q.action == ipbf_pkg::ActPacket);
  assign wr_en  = advance && (item_q.action == ipbf_pkg::ActWrite);

  // frame parsing
  ipbf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pkt_en),
    .data_byte_i (item_q.data_byte),
    .last_byte_i (item_q.last_byte),
    .frame_o     (frame),
    .count_o     (count)
  );

  // block tables
  ipbf_table #(.Entries(TableDepth), .KeyW(32)) u_src_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en && (item_q.table_select == ipbf_pkg::TblSrc)),
    .wr_index_i   (item_q.entry_index),
    .wr_key_i     (item_q.entry_key),
    .wr_present_i (item_q.entry_present),
    .lookup_i     (frame.src_addr),
    .hit_o        (src_hit)
  );

  ipbf_table #(.Entries(TableDepth), .KeyW(32)) u_dst_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en && (item_q.table_select == ipbf_pkg::TblDst)),
    .wr_index_i   (item_q.entry_index),
    .wr_key_i     (item_q.entry_key),
    .wr_present_i (item_q.entry_present),
    .lookup_i     (frame.dst_addr),
    .hit_o        (dst_hit)
  );

  ipbf_table #(.Entries(TableDepth), .KeyW(8)) u_proto_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en && (item_q.table_select == ipbf_pkg::TblProto)),
    .wr_index_i   (item_q.entry_index),
    .wr_key_i     (item_q.entry_key[7:0]),
    .wr_present_i (item_q.entry_present),
    .lookup_i     (frame.protocol),
    .hit_o        (proto_hit)
  );

  ipbf_table #(.Entries(TableDepth), .KeyW(16)) u_port_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en && (item_q.table_select == ipbf_pkg::TblPort)),
    .wr_index_i   (item_q.entry_index),
    .wr_key_i     (item_q.entry_key[15:0]),
    .wr_present_i (item_q.entry_present),
    .lookup_i     (frame.l4_port),
    .hit_o        (port_hit)
  );

  // verdict decision
  assign frame_len = {1'b0, count} + 7'd1;
  assign is_tcp    = (frame.protocol == ipbf_pkg::IpprotoTcp);
  assign is_udp    = (frame.protocol == ipbf_pkg::IpprotoUdp);

  always_comb begin
    if (frame_len < ipbf_pkg::MinIpv4Len) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else if (frame.ether_type != ipbf_pkg::EthPIp) begin
      verdict_d = ipbf_pkg::VerdictPass;
    end else if ((frame.src_addr == '0) || (frame.dst_addr == '0)) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else if (src_hit || dst_hit || proto_hit) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else if (is_tcp && (frame_len < ipbf_pkg::MinTcpLen)) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else if (is_udp && (frame_len < ipbf_pkg::MinUdpLen)) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else if ((is_tcp || is_udp) && port_hit) begin
      verdict_d = ipbf_pkg::VerdictDrop;
    end else begin
      verdict_d = ipbf_pkg::VerdictPass;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && produces) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

/* rtl/ipbf_checker.sv */
// port level checks of the blocklist filter, bound to the top level
`timescale 1ns / 1ps
`include "ipv4_packet_blocklist_filter_unit_macros.svh"

module ipbf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic verdict_o
);

  // no result in the cycle after reset is seen
  `IPBF_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_valid_o)

  // input side stalls only behind a stalled result
  `IPBF_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i))

  // stalled input with a pending transaction and no output ready leaves the result valid
  `IPBF_ASSERT(a_stall_persist, clk_i, rst_ni,
    (!in_ready_o && in_valid_i && !out_ready_i) |=> out_valid_o)

  // a pending result holds its verdict
  `IPBF_ASSERT(a_verdict_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(verdict_o)))

endmodule

bind ipv4_packet_blocklist_filter_unit ipbf_checker u_ipbf_checker (.*);

/* sim/ipv4_packet_blocklist_filter_unit_checker.sv */
// verdict predictor and comparator for the ipv4 blocklist filter
`timescale 1ns / 1ps

module ipv4_packet_blocklist_filter_unit_checker #(
  parameter int unsigned TABLE_ENTRIES = ipbf_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           action_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  input  logic [1:0]                     table_select_i,
  input  logic [ipbf_pkg::EntryIdxW-1:0] entry_index_i,
  input  logic [31:0]                    entry_key_i,
  input  logic                           entry_present_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           verdict_i,
  output int                             err_cnt_o,
  output int                             pending_o,
  output int                             pass_cnt_o,
  output int                             drop_cnt_o
);

  import ipbf_pkg::*;

  typedef struct packed {
    logic        hit_en;
    logic [31:0] key;
  } blk_slot_t;

  // model state: frame capture and the four block tables
  logic [5:0]  byte_cnt;
  ipbf_frame_t fr;
  blk_slot_t   blk [4][TABLE_ENTRIES];
  logic        verdict_q [$];

  function automatic logic table_hit(input ipbf_table_e sel, input logic [31:0] key);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (blk[sel][i].hit_en && blk[sel][i].key == key) hit = 1'b1;
    end
    return hit;
  endfunction

  // pass or drop decision for the frame captured so far
  function automatic logic frame_verdict();
    logic [6:0] len;
    logic       is_tcp;
    logic       is_udp;
    len    = {1'b0, byte_cnt} + 7'd1;
    is_tcp = (fr.protocol == IpprotoTcp);
    is_udp = (fr.protocol == IpprotoUdp);
    if (len < MinIpv4Len) return VerdictDrop;
    if (fr.ether_type != EthPIp) return VerdictPass;
    if (fr.src_addr == '0 || fr.dst_addr == '0) return VerdictDrop;
    if (table_hit(TblSrc, fr.src_addr) || table_hit(TblDst, fr.dst_addr) ||
        table_hit(TblProto, {24'd0, fr.protocol})) return VerdictDrop;
    if (is_tcp && len < MinTcpLen) return VerdictDrop;
    if (is_udp && len < MinUdpLen) return VerdictDrop;
    if ((is_tcp || is_udp) && table_hit(TblPort, {16'd0, fr.l4_port})) return VerdictDrop;
    return VerdictPass;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] wkey;
    logic        exp_v;
    if (!rst_ni) begin
      byte_cnt = '0;
      fr = '0;
      for (int t = 0; t < 4; t++) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) blk[t][i] = '0;
      end
      verdict_q.delete();
      err_cnt_o  = 0;
      pass_cnt_o = 0;
      drop_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (action_i == ActWrite) begin
          // table write takes effect at once, frame state untouched
          wkey = entry_key_i;
          case (ipbf_table_e'(table_select_i))
            TblProto: wkey = wkey & 32'h0000_00ff;
            TblPort:  wkey = wkey & 32'h0000_ffff;
            default:  ;
          endcase
          if (entry_index_i < TABLE_ENTRIES) begin
            blk[table_select_i][entry_index_i].hit_en = entry_present_i;
            blk[table_select_i][entry_index_i].key    = wkey;
          end
        end else begin
          // capture header bytes at fixed offsets
          case (byte_cnt)
            6'd12, 6'd13:               fr.ether_type = {fr.ether_type[7:0], data_byte_i};
            6'd23:                      fr.protocol = data_byte_i;
            6'd26, 6'd27, 6'd28, 6'd29: fr.src_addr = {fr.src_addr[23:0], data_byte_i};
            6'd30, 6'd31, 6'd32, 6'd33: fr.dst_addr = {fr.dst_addr[23:0], data_byte_i};
            6'd36, 6'd37:               fr.l4_port = {fr.l4_port[7:0], data_byte_i};
            default: ;
          endcase
          if (last_byte_i) begin
            verdict_q.push_back(frame_verdict());
            byte_cnt = '0;
            fr = '0;
          end else if (byte_cnt != CountMax) begin
            byte_cnt = byte_cnt + 6'd1;
          end
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10)
            $display("%0t: verdict %0b with no frame pending", $realtime, verdict_i);
        end else begin
          exp_v = verdict_q.pop_front();
          if (verdict_i !== exp_v) begin
            err_cnt_o++;
            if (err_cnt_o <= 10)
              $display("%0t: verdict mismatch, expected %0b got %0b",
                       $realtime, exp_v, verdict_i);
          end
          if (verdict_i === VerdictPass) pass_cnt_o++;
          else drop_cnt_o++;
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

/* sim/ipv4_packet_blocklist_filter_unit_tb.sv */
// stimulus, reset and verdict for the ipv4 blocklist filter testbench
`timescale 1ns / 1ps

module ipv4_packet_blocklist_filter_unit_tb;

  import ipbf_pkg::*;

  localparam int RandItems = 1200;
  localparam int HoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [1:0]  table_select = '0;
  logic [3:0]  entry_index = '0;
  logic [31:0] entry_key = '0;
  logic        entry_present = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        verdict;

  int err_cnt, pending, pass_cnt, drop_cnt;
  int items_sent = 0, frames_sent = 0, writes_sent = 0;
  bit tx_no_gap = 1'b0;
  bit hold_req = 1'b0;
  int write_mix = 0;

  logic [7:0]  frame_buf [128];
  logic [31:0] addr_pool [32];
  logic [15:0] port_pool [16];

  always #2 clk_i = ~clk_i;

  ipv4_packet_blocklist_filter_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .table_select_i  (table_select),
    .entry_index_i   (entry_index),
    .entry_key_i     (entry_key),
    .entry_present_i (entry_present),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .verdict_o       (verdict)
  );

  ipv4_packet_blocklist_filter_unit_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .table_select_i  (table_select),
    .entry_index_i   (entry_index),
    .entry_key_i     (entry_key),
    .entry_present_i (entry_present),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .verdict_i       (verdict),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .pass_cnt_o      (pass_cnt),
    .drop_cnt_o      (drop_cnt)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_proto(input bit for_table);
    int r;
    logic [7:0] rare;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0:       rare = 8'd1;
      1:       rare = 8'd47;
      2:       rare = 8'd50;
      default: rare = 8'd89;
    endcase
    if (for_table) begin
      if (r < 3) return IpprotoTcp;
      if (r < 6) return IpprotoUdp;
      if (r < 85) return rare;
    end else begin
      if (r < 40) return IpprotoTcp;
      if (r < 75) return IpprotoUdp;
      if (r < 90) return rare;
    end
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 55) return addr_pool[$urandom_range(31)];
    return $urandom;
  endfunction

  // one input transaction, held until accepted, then an optional gap
  task automatic send_item(input ipbf_action_e act, input logic [7:0] b, input logic lst,
                           input ipbf_table_e sel, input logic [3:0] idx,
                           input logic [31:0] key, input logic pres);
    int gap;
    in_valid      <= 1'b1;
    action        <= act;
    data_byte     <= b;
    last_byte     <= lst;
    table_select  <= sel;
    entry_index   <= idx;
    entry_key     <= key;
    entry_present <= pres;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    gap = tx_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    if (lst) frames_sent++;
    send_item(ActPacket, b, lst, ipbf_table_e'($urandom_range(3)), 4'($urandom_range(15)),
              $urandom, 1'($urandom_range(1)));
  endtask

  task automatic write_entry(input ipbf_table_e sel, input logic [3:0] idx,
                             input logic [31:0] key, input logic pres);
    writes_sent++;
    send_item(ActWrite, 8'($urandom), 1'($urandom_range(1)), sel, idx, key, pres);
  endtask

  task automatic rand_write();
    ipbf_table_e sel;
    logic [31:0] key;
    int r;
    sel = ipbf_table_e'($urandom_range(3));
    key = $urandom;
    r   = $urandom_range(99);
    case (sel)
      TblSrc, TblDst: if (r < 80) key = addr_pool[$urandom_range(31)];
      TblProto:       key[7:0] = pick_proto(1'b1);
      default:        if (r < 80) key[15:0] = port_pool[$urandom_range(15)];
    endcase
    write_entry(sel, 4'($urandom_range(15)), key, 1'($urandom_range(99) < 75));
  endtask

  // random bytes with the header fields laid in at their offsets
  task automatic build_frame(input logic [15:0] et, input logic [7:0] pr,
                             input logic [31:0] sa, input logic [31:0] da,
                             input logic [15:0] dp);
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    {frame_buf[12], frame_buf[13]} = et;
    frame_buf[23] = pr;
    {frame_buf[26], frame_buf[27], frame_buf[28], frame_buf[29]} = sa;
    {frame_buf[30], frame_buf[31], frame_buf[32], frame_buf[33]} = da;
    {frame_buf[36], frame_buf[37]} = dp;
  endtask

  task automatic send_bytes(input int lo, input int hi, input int len);
    for (int i = lo; i <= hi; i++) begin
      if ($urandom_range(99) < write_mix) rand_write();
      push_byte(frame_buf[i], i == len - 1);
    end
  endtask

  task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] pr,
                            input logic [31:0] sa, input logic [31:0] da,
                            input logic [15:0] dp);
    build_frame(et, pr, sa, da, dp);
    send_bytes(0, len - 1, len);
  endtask

  task automatic rand_frame();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 8) len = $urandom_range(1, 33);
    else if (r < 88) len = $urandom_range(34, 70);
    else len = $urandom_range(71, 120);
    write_mix = $urandom_range(5);
    tx_no_gap = ($urandom_range(9) == 0);
    send_frame(len, ($urandom_range(99) < 85) ? EthPIp : 16'($urandom),
               pick_proto(1'b0), pick_addr(), pick_addr(),
               ($urandom_range(1) == 0) ? port_pool[$urandom_range(15)] : 16'($urandom));
  endtask

  // receiver stalls the output while one-byte frames keep coming
  task automatic output_hold();
    tx_no_gap = 1'b1;
    write_mix = 0;
    hold_req  = 1'b1;
    repeat (50) push_byte(8'($urandom), 1'b1);
  endtask

  // output side: random ready with short and long stalls, one long hold on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20))
          @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // reset, directed cases, random traffic, drain and verdict
  initial begin
    logic [31:0] a_src, b_dst, c_src, d_src;
    int rand_start;
    int hold_cnt;
    foreach (addr_pool[i]) addr_pool[i] = $urandom | 32'h1;
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);
    a_src = 32'hc0a8_0001;
    b_dst = 32'h0a00_0002;
    c_src = 32'hac10_0203;
    d_src = 32'h5566_7788;
    hold_cnt = 0;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // extremes, short frames, non-ipv4 and zero addresses with empty tables
    send_frame(64, EthPIp, IpprotoTcp, 32'hffff_ffff, 32'h0000_0001, 16'hffff);
    send_frame(1, EthPIp, IpprotoTcp, a_src, b_dst, 16'd80);
    send_frame(33, EthPIp, IpprotoUdp, a_src, b_dst, 16'd53);
    send_frame(34, 16'h86dd, 8'd0, 32'd0, 32'd0, 16'd0);
    send_frame(40, EthPIp, 8'd1, 32'd0, b_dst, 16'd0);

    // source hit, then absent write lifts it
    write_entry(TblSrc, 4'd0, a_src, 1'b1);
    send_frame(40, EthPIp, 8'd1, a_src, b_dst, 16'd0);
    write_entry(TblSrc, 4'd0, a_src, 1'b0);
    send_frame(40, EthPIp, 8'd1, a_src, b_dst, 16'd0);

    // destination hit in the top slot
    write_entry(TblDst, 4'd15, b_dst, 1'b1);
    send_frame(40, EthPIp, 8'd1, a_src, b_dst, 16'd0);
    write_entry(TblDst, 4'd15, b_dst, 1'b0);

    // wide keys on the narrow protocol and port tables
    write_entry(TblProto, 4'd3, 32'habcd_ef2f, 1'b1);
    send_frame(34, EthPIp, 8'd47, a_src, b_dst, 16'd0);
    write_entry(TblPort, 4'd7, 32'hffff_0050, 1'b1);
    send_frame(42, EthPIp, IpprotoUdp, a_src, b_dst, 16'd80);
    send_frame(42, EthPIp, IpprotoUdp, a_src, b_dst, 16'd81);
    send_frame(41, EthPIp, IpprotoUdp, a_src, b_dst, 16'd81);
    send_frame(53, EthPIp, IpprotoTcp, a_src, b_dst, 16'd81);
    send_frame(54, EthPIp, IpprotoTcp, a_src, b_dst, 16'd81);

    // duplicate keys: one slot cleared, the other still blocks
    write_entry(TblSrc, 4'd1, a_src, 1'b1);
    write_entry(TblSrc, 4'd2, a_src, 1'b1);
    write_entry(TblSrc, 4'd1, a_src, 1'b0);
    send_frame(40, EthPIp, 8'd1, a_src, b_dst, 16'd0);

    // block table write in the middle of a frame applies to that frame
    build_frame(EthPIp, IpprotoTcp, c_src, b_dst, 16'd81);
    send_bytes(0, 39, 60);
    write_entry(TblSrc, 4'd4, c_src, 1'b1);
    send_bytes(40, 59, 60);

    // long frame saturates the byte counter
    send_frame(100, EthPIp, IpprotoTcp, d_src, b_dst, 16'd81);

    write_entry(TblSrc, 4'd2, a_src, 1'b0);
    write_entry(TblSrc, 4'd4, c_src, 1'b0);
    write_entry(TblProto, 4'd3, 32'd0, 1'b0);
    write_entry(TblPort, 4'd7, 32'd0, 1'b0);

    // random traffic: mostly well-formed frames, some noise and table updates
    rand_start = items_sent;
    while (items_sent - rand_start < RandItems || frames_sent < 60) begin
      if (hold_cnt < 2 && items_sent - rand_start > 400 * (hold_cnt + 1)) begin
        output_hold();
        hold_cnt++;
      end else begin
        case ($urandom_range(19))
          0: begin
            write_mix = 0;
            tx_no_gap = 1'b0;
            build_frame(16'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom));
            send_bytes(0, $urandom_range(0, 79), 80);
            push_byte(8'($urandom), 1'b1);
          end
          1, 2: repeat ($urandom_range(1, 4)) rand_write();
          default: rand_frame();
        endcase
      end
    end
    in_valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d transactions: %0d frames judged (%0d pass, %0d drop), %0d table writes",
             items_sent, frames_sent, pass_cnt, drop_cnt, writes_sent);
    $display("random idling on both sides, %0d long output holds, %0d mismatches",
             hold_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
